/* design/esl_pkg.sv */
// Package for the event stream line parser: types, character codes and the
// per-byte parsing functions of the parser core; the checker uses its types.
// No dependencies.
`timescale 1ns / 1ps

package esl_pkg;

    // Retry values must fit in this many bits to be reported.
    localparam int RETRY_BITS = 32;
    localparam int RETRY_WIDE = RETRY_BITS + 4;
    localparam int RES_RETRY_W = 32;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Bit positions in the name miss mask.
    localparam int MISS_DATA = 0;
    localparam int MISS_EVENT = 1;
    localparam int MISS_ID = 2;
    localparam int MISS_RETRY = 3;

    localparam logic [2:0] NAME_POS_MAX = 3'd7;

    typedef enum logic [3:0] {
        K_DATA_BYTE   = 4'd0,
        K_EVENT_CLEAR = 4'd1,
        K_EVENT_BYTE  = 4'd2,
        K_ID_BEGIN    = 4'd3,
        K_ID_BYTE     = 4'd4,
        K_ID_END      = 4'd5,
        K_RETRY_SET   = 4'd6,
        K_DISPATCH    = 4'd7,
        K_DISCARD     = 4'd8
    } t_kind;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_NAME    = 2'd1,
        PH_VALUE   = 2'd2,
        PH_COMMENT = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        SEL_NONE  = 3'd0,
        SEL_DATA  = 3'd1,
        SEL_EVENT = 3'd2,
        SEL_ID    = 3'd3,
        SEL_RETRY = 3'd4
    } t_sel;

    typedef struct packed {
        t_phase                  phase;
        logic [2:0]              name_pos;
        logic [3:0]              name_miss;
        t_sel                    field_sel;
        logic                    first_value;
        logic                    newline_owed;
        logic                    data_present;
        logic                    name_present;
        logic                    id_nul_seen;
        logic [RETRY_BITS-1:0]   retry_acc;
        logic                    retry_invalid;
        logic                    retry_digit_seen;
    } t_state;

    localparam t_state STATE_RESET = '0;

    typedef struct packed {
        t_kind                   kind;
        logic [7:0]              data;
        logic [RES_RETRY_W-1:0]  retry;
        logic                    id_ok;
        logic                    named;
        logic                    last;
    } t_result;

    // One content byte: at most one result.
    typedef struct packed {
        t_state  st;
        logic    hit;
        t_result res;
    } t_step;

    // Up to two results pushed into the result queue in the same cycle.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        t_state st;
        t_push  push;
    } t_step2;

    function automatic t_result mk_res(t_kind kind, logic [7:0] data,
                                       logic [RES_RETRY_W-1:0] retry,
                                       logic ok, logic named);
        t_result r;
        r.kind = kind;
        r.data = data;
        r.retry = retry;
        r.id_ok = ok;
        r.named = named;
        r.last = 1'b0;
        return r;
    endfunction

    // True when byte c matches the field name sel at position pos.
    function automatic logic name_hit(t_sel sel, logic [2:0] pos, logic [7:0] c);
        logic hit;
        hit = 1'b0;
        case (sel)
            SEL_DATA: begin
                case (pos)
                    3'd0: hit = (c == "d");
                    3'd1: hit = (c == "a");
                    3'd2: hit = (c == "t");
                    3'd3: hit = (c == "a");
                    default: hit = 1'b0;
                endcase
            end
            SEL_EVENT: begin
                case (pos)
                    3'd0: hit = (c == "e");
                    3'd1: hit = (c == "v");
                    3'd2: hit = (c == "e");
                    3'd3: hit = (c == "n");
                    3'd4: hit = (c == "t");
                    default: hit = 1'b0;
                endcase
            end
            SEL_ID: begin
                case (pos)
                    3'd0: hit = (c == "i");
                    3'd1: hit = (c == "d");
                    default: hit = 1'b0;
                endcase
            end
            SEL_RETRY: begin
                case (pos)
                    3'd0: hit = (c == "r");
                    3'd1: hit = (c == "e");
                    3'd2: hit = (c == "t");
                    3'd3: hit = (c == "r");
                    3'd4: hit = (c == "y");
                    default: hit = 1'b0;
                endcase
            end
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Advance the name matcher by one byte; position saturates.
    function automatic t_state name_char(t_state st, logic [7:0] c);
        t_state s;
        s = st;
        if (!name_hit(SEL_DATA, st.name_pos, c))  s.name_miss[MISS_DATA] = 1'b1;
        if (!name_hit(SEL_EVENT, st.name_pos, c)) s.name_miss[MISS_EVENT] = 1'b1;
        if (!name_hit(SEL_ID, st.name_pos, c))    s.name_miss[MISS_ID] = 1'b1;
        if (!name_hit(SEL_RETRY, st.name_pos, c)) s.name_miss[MISS_RETRY] = 1'b1;
        if (st.name_pos != NAME_POS_MAX) s.name_pos = st.name_pos + 3'd1;
        return s;
    endfunction

    function automatic t_sel match_field(t_state st);
        t_sel sel;
        if (!st.name_miss[MISS_DATA] && st.name_pos == 3'd4) begin
            sel = SEL_DATA;
        end else if (!st.name_miss[MISS_EVENT] && st.name_pos == 3'd5) begin
            sel = SEL_EVENT;
        end else if (!st.name_miss[MISS_ID] && st.name_pos == 3'd2) begin
            sel = SEL_ID;
        end else if (!st.name_miss[MISS_RETRY] && st.name_pos == 3'd5) begin
            sel = SEL_RETRY;
        end else begin
            sel = SEL_NONE;
        end
        return sel;
    endfunction

    // One byte that is part of a line (not a line end).
    function automatic t_step content_byte(t_state st, logic [7:0] c);
        t_step                 o;
        logic                  skip;
        logic [RETRY_WIDE-1:0] wide;
        o.st = st;
        o.hit = 1'b0;
        o.res = mk_res(K_DATA_BYTE, 8'h00, '0, 1'b0, 1'b0);
        skip = 1'b0;
        wide = (RETRY_WIDE'(st.retry_acc) << 3) + (RETRY_WIDE'(st.retry_acc) << 1)
             + RETRY_WIDE'(c[3:0]);
        case (st.phase)
            PH_START: begin
                if (c == CH_COLON) begin
                    o.st.phase = PH_COMMENT;
                end else begin
                    o.st.phase = PH_NAME;
                    o.st.name_pos = 3'd0;
                    o.st.name_miss = 4'd0;
                    o.st = name_char(o.st, c);
                end
            end
            PH_NAME: begin
                if (c == CH_COLON) begin
                    // Field name complete: select the field and open the value
                    o.st.field_sel = match_field(st);
                    o.st.phase = PH_VALUE;
                    o.st.first_value = 1'b1;
                    case (o.st.field_sel)
                        SEL_DATA: begin
                            if (st.newline_owed) begin
                                o.hit = 1'b1;
                                o.res = mk_res(K_DATA_BYTE, CH_LF, '0, 1'b0, 1'b0);
                                o.st.newline_owed = 1'b0;
                            end
                        end
                        SEL_EVENT: begin
                            o.hit = 1'b1;
                            o.res = mk_res(K_EVENT_CLEAR, 8'h00, '0, 1'b0, 1'b0);
                            o.st.name_present = 1'b0;
                        end
                        SEL_ID: begin
                            o.hit = 1'b1;
                            o.res = mk_res(K_ID_BEGIN, 8'h00, '0, 1'b0, 1'b0);
                            o.st.id_nul_seen = 1'b0;
                        end
                        SEL_RETRY: begin
                            o.st.retry_acc = '0;
                            o.st.retry_invalid = 1'b0;
                            o.st.retry_digit_seen = 1'b0;
                        end
                        default: ;
                    endcase
                end else begin
                    o.st = name_char(st, c);
                end
            end
            PH_VALUE: begin
                // Drop one leading space of the value
                if (st.first_value) begin
                    o.st.first_value = 1'b0;
                    skip = (c == CH_SPACE);
                end
                if (!skip) begin
                    case (st.field_sel)
                        SEL_DATA: begin
                            o.hit = 1'b1;
                            o.res = mk_res(K_DATA_BYTE, c, '0, 1'b0, 1'b0);
                        end
                        SEL_EVENT: begin
                            o.hit = 1'b1;
                            o.res = mk_res(K_EVENT_BYTE, c, '0, 1'b0, 1'b0);
                            o.st.name_present = 1'b1;
                        end
                        SEL_ID: begin
                            o.hit = 1'b1;
                            o.res = mk_res(K_ID_BYTE, c, '0, 1'b0, 1'b0);
                            if (c == 8'h00) o.st.id_nul_seen = 1'b1;
                        end
                        SEL_RETRY: begin
                            if (c < CH_ZERO || c > CH_NINE) begin
                                o.st.retry_invalid = 1'b1;
                            end else if (!st.retry_invalid) begin
                                o.st.retry_digit_seen = 1'b1;
                                if (|wide[RETRY_WIDE-1:RETRY_BITS]) begin
                                    o.st.retry_invalid = 1'b1;
                                end else begin
                                    o.st.retry_acc = wide[RETRY_BITS-1:0];
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // Line end (LF, or CR LF).
    function automatic t_step2 line_end(t_state st);
        t_step2 o;
        t_sel   sel;
        o.st = st;
        o.push.cnt = 2'd0;
        o.push.res0 = mk_res(K_DATA_BYTE, 8'h00, '0, 1'b0, 1'b0);
        o.push.res1 = mk_res(K_DATA_BYTE, 8'h00, '0, 1'b0, 1'b0);
        sel = match_field(st);
        case (st.phase)
            PH_START: begin
                o.push.cnt = 2'd1;
                if (st.data_present) begin
                    o.push.res0 = mk_res(K_DISPATCH, 8'h00, '0, 1'b0, st.name_present);
                end else begin
                    o.push.res0 = mk_res(K_DISCARD, 8'h00, '0, 1'b0, 1'b0);
                end
                o.st.data_present = 1'b0;
                o.st.name_present = 1'b0;
                o.st.newline_owed = 1'b0;
            end
            PH_NAME: begin
                // Field without a colon: empty value
                case (sel)
                    SEL_DATA: begin
                        if (st.newline_owed) begin
                            o.push.cnt = 2'd1;
                            o.push.res0 = mk_res(K_DATA_BYTE, CH_LF, '0, 1'b0, 1'b0);
                        end
                        o.st.newline_owed = 1'b1;
                        o.st.data_present = 1'b1;
                    end
                    SEL_EVENT: begin
                        o.push.cnt = 2'd1;
                        o.push.res0 = mk_res(K_EVENT_CLEAR, 8'h00, '0, 1'b0, 1'b0);
                        o.st.name_present = 1'b0;
                    end
                    SEL_ID: begin
                        o.push.cnt = 2'd2;
                        o.push.res0 = mk_res(K_ID_BEGIN, 8'h00, '0, 1'b0, 1'b0);
                        o.push.res1 = mk_res(K_ID_END, 8'h00, '0, 1'b1, 1'b0);
                    end
                    default: ;
                endcase
            end
            PH_VALUE: begin
                case (st.field_sel)
                    SEL_DATA: begin
                        o.st.newline_owed = 1'b1;
                        o.st.data_present = 1'b1;
                    end
                    SEL_ID: begin
                        o.push.cnt = 2'd1;
                        o.push.res0 = mk_res(K_ID_END, 8'h00, '0, !st.id_nul_seen, 1'b0);
                    end
                    SEL_RETRY: begin
                        if (st.retry_digit_seen && !st.retry_invalid) begin
                            o.push.cnt = 2'd1;
                            o.push.res0 = mk_res(K_RETRY_SET, 8'h00,
                                                 RES_RETRY_W'(st.retry_acc), 1'b0, 1'b0);
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        o.st.phase = PH_START;
        o.st.field_sel = SEL_NONE;
        o.st.first_value = 1'b0;
        o.st.name_pos = 3'd0;
        o.st.name_miss = 4'd0;
        return o;
    endfunction

endpackage

/* design/esl_parser.sv */
// Parser core: line state and CR hold-back, one byte per step, up to two
// results per byte. Depends on esl_pkg.
`timescale 1ns / 1ps

module esl_parser
    import esl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_push      o_push
);

    t_state r_state, n_state;
    logic   r_cr_pending, n_cr_pending;
    t_step  first_step;
    t_step  second_step;
    t_step2 end_step;
    t_push  push;

    // Candidate steps: line end, held/plain content byte, byte after a held CR
    assign end_step = line_end(r_state);
    assign first_step = content_byte(r_state, r_cr_pending ? CH_CR : i_byte);
    assign second_step = content_byte(first_step.st, i_byte);

    // Pick the path for this byte and collect its results
    always_comb begin
        n_state = r_state;
        n_cr_pending = r_cr_pending;
        push.cnt = 2'd0;
        push.res0 = mk_res(K_DATA_BYTE, 8'h00, '0, 1'b0, 1'b0);
        push.res1 = push.res0;
        if (r_cr_pending) begin
            n_cr_pending = 1'b0;
            if (i_byte == CH_LF) begin
                n_state = end_step.st;
                push = end_step.push;
            end else if (i_byte == CH_CR) begin
                // Held CR becomes content; the new CR is held in turn
                n_cr_pending = 1'b1;
                n_state = first_step.st;
                push.cnt = {1'b0, first_step.hit};
                push.res0 = first_step.res;
            end else begin
                n_state = second_step.st;
                if (first_step.hit) begin
                    push.res0 = first_step.res;
                    push.res1 = second_step.res;
                    push.cnt = second_step.hit ? 2'd2 : 2'd1;
                end else begin
                    push.res0 = second_step.res;
                    push.cnt = {1'b0, second_step.hit};
                end
            end
        end else if (i_byte == CH_CR) begin
            n_cr_pending = 1'b1;
        end else if (i_byte == CH_LF) begin
            n_state = end_step.st;
            push = end_step.push;
        end else begin
            n_state = first_step.st;
            push.cnt = {1'b0, first_step.hit};
            push.res0 = first_step.res;
        end
        // Mark the final result of this byte
        push.res0.last = (push.cnt == 2'd1);
        push.res1.last = 1'b1;
    end

    assign o_push.cnt = i_step ? push.cnt : 2'd0;
    assign o_push.res0 = push.res0;
    assign o_push.res1 = push.res1;

    // Advance the parser state on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_cr_pending <= 1'b0;
        end else if (i_step) begin
            r_state <= n_state;
            r_cr_pending <= n_cr_pending;
        end
    end

endmodule

/* design/esl_res_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per cycle when popped.
// Depends on esl_pkg.
`timescale 1ns / 1ps

module esl_res_fifo
    import esl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic                 pop;

    assign o_valid = (r_count != '0);
    assign o_head = r_mem[r_rd_ptr];
    assign pop = o_valid && i_pop;
    // Room for a worst-case byte, judged on the registered count only
    assign o_room = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(i_push.cnt);
        n_rd_ptr = r_rd_ptr + FIFO_AW'(pop);
        n_count = r_count + FIFO_CW'(i_push.cnt) - FIFO_CW'(pop);
    end

    // Store incoming results
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wr_ptr] <= i_push.res0;
        if (i_push.cnt == 2'd2) r_mem[r_wr_ptr + FIFO_AW'(1)] <= i_push.res1;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

endmodule

/* design/event_stream_line_parser.sv */
// Top level of the event stream line parser: input register, parser core
// and result queue. Depends on esl_pkg, esl_parser and esl_res_fifo.
//
// Usage: feed raw stream bytes on i_in_byte with i_in_valid; a byte is
// transferred at a clock edge where i_in_valid is high and o_in_stall low.
// Each byte yields zero, one or two tagged results on the output channel
// (o_kind, o_out_byte, o_retry_value, o_id_ok, o_named_event, o_last),
// transferred where o_out_valid is high and i_out_stall low. o_last marks
// the final result of a byte. A CR is held until the next byte arrives.
// A transferred byte waits in the input register while the queue lacks room;
// once parsed, its results are written into the queue and offered from its head.
// Throughput: one byte per cycle while each byte yields at most one
// result and the receiver does not stall; the single output port sets the
// rate at one result per cycle, so a byte with two results holds the output
// for both of them in turn. The four-entry result queue absorbs the
// difference and stalls the input when fewer than two entries are free.
// Reset (synchronous, active low) clears the line state, the held CR and
// the queue. While the receiver stalls, the head result holds and the
// queue fills, then o_in_stall rises; no result is lost.
`timescale 1ns / 1ps

module event_stream_line_parser
    import esl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_in_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [3:0]             o_kind,
    output logic [7:0]             o_out_byte,
    output logic [RES_RETRY_W-1:0] o_retry_value,
    output logic                   o_id_ok,
    output logic                   o_named_event,
    output logic                   o_last
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       room;
    logic       step;
    logic       accept;
    t_push      push;
    t_result    head;

    // Input register handshake
    assign step = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) n_in_valid = 1'b1;
        else if (step) n_in_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Hold the byte until the parser takes it
    always_ff @(posedge i_clk) begin
        if (accept) r_in_byte <= i_in_byte;
    end

    esl_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    esl_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_out_stall),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    // Drive result fields from the queue head
    assign o_kind = head.kind;
    assign o_out_byte = head.data;
    assign o_retry_value = head.retry;
    assign o_id_ok = head.id_ok;
    assign o_named_event = head.named;
    assign o_last = head.last;

endmodule

/* design/esl_checker.sv */
// Port-level checks for the event stream line parser, bound to the top level.
// Depends on esl_pkg and event_stream_line_parser.
`timescale 1ns / 1ps

module esl_checker
    import esl_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [3:0]             o_kind,
    input logic [7:0]             o_out_byte,
    input logic [RES_RETRY_W-1:0] o_retry_value,
    input logic                   o_id_ok,
    input logic                   o_named_event,
    input logic                   o_last
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) && $stable(o_last))
        else $error("stalled result changed");

    // Queue is empty right after reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    // Payload byte only on data, event and id byte kinds
    a_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != K_DATA_BYTE && o_kind != K_EVENT_BYTE
        && o_kind != K_ID_BYTE |-> o_out_byte == 8'h00)
        else $error("payload byte on a control kind");

    // Retry value only on retry set
    a_retry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != K_RETRY_SET |-> o_retry_value == '0)
        else $error("retry value on a non-retry kind");

    // Flags only on their own kinds; a dispatch or discard ends a byte's results
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == K_ID_END || !o_id_ok)
        && (o_kind == K_DISPATCH || !o_named_event)
        && ((o_kind != K_DISPATCH && o_kind != K_DISCARD) || o_last))
        else $error("flag on wrong kind");

endmodule

bind event_stream_line_parser esl_checker u_esl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kind        (o_kind),
    .o_out_byte    (o_out_byte),
    .o_retry_value (o_retry_value),
    .o_id_ok       (o_id_ok),
    .o_named_event (o_named_event),
    .o_last        (o_last)
);
